FILE: hdl/sha256_pkg.sv
// Shared types, constants and round functions of the SHA-256 hasher.
package sha256_pkg;

    typedef logic [31:0] t_word;

    // One queued message item after classification
    typedef struct packed {
        t_word      word;
        logic [2:0] cnt;
        logic       last;
    } t_item;

    localparam logic [2:0] MAX_COUNT  = 3'd4;
    localparam t_word      PAD_WORD   = 32'h8000_0000;
    localparam logic [5:0] PAD_LIMIT  = 6'd56;
    localparam int         LEN_HI_IDX = 14;
    localparam int         LEN_LO_IDX = 15;

    localparam t_word INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Compression sigma: rotate by 2, 13, 22
    function automatic t_word big_sigma0(input t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    // Compression sigma: rotate by 6, 11, 25
    function automatic t_word big_sigma1(input t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    // Schedule sigma: rotate by 7, 18, shift by 3
    function automatic t_word small_sigma0(input t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
    endfunction

    // Schedule sigma: rotate by 17, 19, shift by 10
    function automatic t_word small_sigma1(input t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
    endfunction

endpackage

FILE: hdl/sha256_hasher.sv
// Top level of the streaming SHA-256 hasher.
//
//  channel  direction  handshake          payload
//  message  in         i_valid / o_stall  i_message_word, i_byte_count, i_last_word
//  digest   out        o_valid / i_stall  o_digest_word, o_word_index, o_digest_end
//
// A message item is packed into the 64-byte block in one load step; a part that
// spills over the block end is held and packed after the compression. Each full
// block then takes 64 rounds at one per cycle and one chaining add.
// The last item adds a pad step, a length step, one or two blocks and the eight
// digest words. Reset is synchronous; the hash starts at the initial values
// with no clearing pass. A queue of QUEUE_DEPTH items takes input during
// rounds; an output stall holds the digest register, and the engine while it
// emits digest words.
module sha256_hasher import sha256_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_message_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_last_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_digest_end
);

    logic  w_push;
    t_item w_push_item;
    logic  w_q_full;
    logic  w_q_empty;
    logic  w_pop;
    t_item w_head;

    sha256_front u_front (
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_message_word (i_message_word),
        .i_byte_count   (i_byte_count),
        .i_last_word    (i_last_word),
        .i_q_full       (w_q_full),
        .o_push         (w_push),
        .o_item         (w_push_item)
    );

    sha256_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_empty (w_q_empty),
        .o_item  (w_head)
    );

    sha256_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (w_q_empty),
        .i_q_item      (w_head),
        .o_q_pop       (w_pop),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_digest_end  (o_digest_end)
    );

`ifndef NO_ASSERTIONS
    // Digest words follow each other without a gap, in index order
    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_digest_end) |=>
            (o_valid && (o_word_index == $past(o_word_index) + 3'd1)))
        else $error("digest word out of order");

    // A word right after the eighth one opens a new digest
    a_end_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_digest_end) |=> (!o_valid || (o_word_index == 3'd0)))
        else $error("digest word after end");

    // The end flag marks exactly the eighth word
    a_end_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_digest_end == (o_word_index == 3'd7)))
        else $error("end flag mismatch");

    // Reset empties the output register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");
`endif

endmodule

FILE: hdl/sha256_front.sv
// Input front end: accepts items, clamps the byte count and drops empty items that do not close the message.
module sha256_front import sha256_pkg::*; (
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_message_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_last_word,
    input  logic        i_q_full,
    output logic        o_push,
    output t_item       o_item
);

    logic       w_accept;
    logic [2:0] w_cnt;

    // Hold off the source while the queue is full
    assign o_stall  = i_q_full;
    assign w_accept = i_valid && !i_q_full;

    // Clamp counts above four
    assign w_cnt = (i_byte_count > MAX_COUNT) ? MAX_COUNT : i_byte_count;

    // Drop an empty item that does not close the message
    assign o_push      = w_accept && ((w_cnt != 3'd0) || i_last_word);
    assign o_item.word = i_message_word;
    assign o_item.cnt  = w_cnt;
    assign o_item.last = i_last_word;

endmodule

FILE: hdl/sha256_queue.sv
// Small item queue between the front end and the compression engine.
module sha256_queue import sha256_pkg::*; #(
    parameter int unsigned DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_item
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W-1:0] r_wr;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rd];

    // Advance pointers and the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PTR_W'(1);
            end
            r_cnt <= r_cnt + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

    // Store the pushed item
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

FILE: hdl/sha256_back.sv
// Compression engine: block packing, padding, 64 rounds and digest output.
module sha256_back import sha256_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_item       i_q_item,
    output logic        o_q_pop,
    input  logic        i_stall,
    output logic        o_valid,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_digest_end
);

    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_ROUND = 4'b0010,
        ST_ADD   = 4'b0100,
        ST_OUT   = 4'b1000
    } t_state;

    t_state      r_state, n_state;
    t_word       r_h [8], n_h [8];
    t_word       r_v [8], n_v [8];
    t_word       r_w [16], n_w [16];
    logic [5:0]  r_round, n_round;
    logic [5:0]  r_fill, n_fill;
    logic [60:0] r_len, n_len;
    t_item       r_pend, n_pend;
    logic        r_pend_act, n_pend_act;
    logic        r_pad_done, n_pad_done;
    logic        r_final, n_final;
    logic [2:0]  r_widx, n_widx;
    logic        r_ovalid, n_ovalid;
    t_word       r_oword, n_oword;
    logic [2:0]  r_oidx, n_oidx;
    logic        r_oend, n_oend;

    t_item       w_cur;
    logic        w_load;
    logic        w_pad_done;
    logic [6:0]  w_space;
    logic [2:0]  w_take;
    logic        w_is_data;
    logic        w_is_pad;
    t_word       w_place_word;
    logic [2:0]  w_place_n;
    logic [6:0]  w_fill_sum;
    logic        w_start;
    logic        w_len_write;
    logic [63:0] w_bits;
    logic        w_out_free;
    t_word       w_t1, w_t2, w_ch, w_maj, w_sched;

    // Select the item being packed: a held remainder first, else the queue head
    assign w_cur      = r_pend_act ? r_pend : i_q_item;
    assign w_load     = (r_state == ST_LOAD) && (r_pend_act || !i_q_empty);
    assign o_q_pop    = (r_state == ST_LOAD) && !r_pend_act && !i_q_empty;
    assign w_pad_done = r_pend_act && r_pad_done;

    // Bytes that fit into the current block
    assign w_space   = 7'd64 - {1'b0, r_fill};
    assign w_take    = ({4'b0, w_cur.cnt} > w_space) ? w_space[2:0] : w_cur.cnt;
    assign w_is_data = (w_cur.cnt != 3'd0);
    assign w_is_pad  = !w_is_data && !w_pad_done;

    assign w_place_word = w_is_data ? w_cur.word : PAD_WORD;
    assign w_place_n    = w_is_data ? w_take : (w_is_pad ? 3'd1 : 3'd0);
    assign w_fill_sum   = {1'b0, r_fill} + {4'b0, w_place_n};

    // Start a compression on a full block, a spill block or the length block
    assign w_start     = w_load && ((w_fill_sum == 7'd64) || (!w_is_data && w_pad_done));
    assign w_len_write = w_load && !w_is_data && w_pad_done && (r_fill <= PAD_LIMIT);
    assign w_bits      = {r_len, 3'b000};

    assign w_out_free = !r_ovalid || !i_stall;

    // Round datapath and message schedule
    assign w_ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign w_maj   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign w_t1    = r_v[7] + big_sigma1(r_v[4]) + w_ch + ROUND_K[r_round] + r_w[0];
    assign w_t2    = big_sigma0(r_v[0]) + w_maj;
    assign w_sched = small_sigma1(r_w[14]) + r_w[9] + small_sigma0(r_w[1]) + r_w[0];

    // Sequence packing, rounds, chaining and digest output
    always_comb begin
        logic [6:0] rel;
        rel        = '0;
        n_state    = r_state;
        n_h        = r_h;
        n_v        = r_v;
        n_w        = r_w;
        n_round    = r_round;
        n_fill     = r_fill;
        n_len      = r_len;
        n_pend     = r_pend;
        n_pend_act = r_pend_act;
        n_pad_done = r_pad_done;
        n_final    = r_final;
        n_widx     = r_widx;
        n_ovalid   = r_ovalid && i_stall;
        n_oword    = r_oword;
        n_oidx     = r_oidx;
        n_oend     = r_oend;

        unique case (r_state)
            ST_LOAD: begin
                if (w_load) begin
                    // Place message or pad bytes at the fill position
                    for (int b = 0; b < 64; b++) begin
                        rel = 7'(b) - {1'b0, r_fill};
                        if (rel < {4'b0, w_place_n}) begin
                            n_w[b >> 2][8 * (3 - (b & 3)) +: 8] =
                                w_place_word[8 * (3 - int'(rel[1:0])) +: 8];
                        end
                    end
                    if (w_is_data) begin
                        n_len       = r_len + {58'b0, w_take};
                        n_pend.word = w_cur.word << {w_take, 3'b000};
                        n_pend.cnt  = w_cur.cnt - w_take;
                        n_pend.last = w_cur.last;
                        n_pend_act  = (w_cur.cnt != w_take) || w_cur.last;
                        n_pad_done  = 1'b0;
                    end else begin
                        n_pend     = w_cur;
                        n_pend_act = 1'b1;
                        n_pad_done = 1'b1;
                    end
                    // Append the bit length in the last two words
                    if (w_len_write) begin
                        n_w[LEN_HI_IDX] = w_bits[63:32];
                        n_w[LEN_LO_IDX] = w_bits[31:0];
                        n_final         = 1'b1;
                    end
                    if (w_start) begin
                        n_v     = r_h;
                        n_round = '0;
                        n_state = ST_ROUND;
                    end else begin
                        n_fill = w_fill_sum[5:0];
                    end
                end
            end
            ST_ROUND: begin
                n_v[0] = w_t1 + w_t2;
                n_v[1] = r_v[0];
                n_v[2] = r_v[1];
                n_v[3] = r_v[2];
                n_v[4] = r_v[3] + w_t1;
                n_v[5] = r_v[4];
                n_v[6] = r_v[5];
                n_v[7] = r_v[6];
                for (int i = 0; i < 15; i++) begin
                    n_w[i] = r_w[i + 1];
                end
                n_w[15] = w_sched;
                n_round = r_round + 6'd1;
                if (r_round == 6'd63) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                // Chain the block result and clear the block buffer
                for (int i = 0; i < 8; i++) begin
                    n_h[i] = r_h[i] + r_v[i];
                end
                n_w    = '{default: '0};
                n_fill = '0;
                if (r_final) begin
                    n_state    = ST_OUT;
                    n_widx     = '0;
                    n_final    = 1'b0;
                    n_pend_act = 1'b0;
                    n_pad_done = 1'b0;
                    n_len      = '0;
                end else begin
                    n_state = ST_LOAD;
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_oword  = r_h[r_widx];
                    n_oidx   = r_widx;
                    n_oend   = (r_widx == 3'd7);
                    n_widx   = r_widx + 3'd1;
                    if (r_widx == 3'd7) begin
                        n_h     = INIT_HASH;
                        n_state = ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // Update control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_h        <= INIT_HASH;
            r_w        <= '{default: '0};
            r_round    <= '0;
            r_fill     <= '0;
            r_len      <= '0;
            r_pend_act <= 1'b0;
            r_pad_done <= 1'b0;
            r_final    <= 1'b0;
            r_widx     <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_h        <= n_h;
            r_w        <= n_w;
            r_round    <= n_round;
            r_fill     <= n_fill;
            r_len      <= n_len;
            r_pend_act <= n_pend_act;
            r_pad_done <= n_pad_done;
            r_final    <= n_final;
            r_widx     <= n_widx;
            r_ovalid   <= n_ovalid;
        end
    end

    // Update payload registers
    always_ff @(posedge i_clk) begin
        r_v     <= n_v;
        r_pend  <= n_pend;
        r_oword <= n_oword;
        r_oidx  <= n_oidx;
        r_oend  <= n_oend;
    end

    assign o_valid       = r_ovalid;
    assign o_digest_word = r_oword;
    assign o_word_index  = r_oidx;
    assign o_digest_end  = r_oend;

endmodule
